>>> rtl/core/mtm_pkg.sv
// shared constants, codes and types of the matrix multiply unit
// no dependencies; every other file but mtm_ram imports this package
`default_nettype none

package mtm_pkg;

  // size limits of the result matrix and of the inner dimension
  localparam int MAX_ROWS  = 16;
  localparam int MAX_INNER = 64;
  localparam int MAX_COLS  = 16;

  // element stores
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;

  // field widths
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 10;
  localparam int VAL_W   = 16;
  localparam int ROWS_W  = 5;
  localparam int INNER_W = 7;
  localparam int COLS_W  = 5;
  localparam int LAYOUT_W = 2;
  localparam int OUT_IDX_W = 4;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = 48;

  // transaction modes
  localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  // layouts
  localparam logic [LAYOUT_W-1:0] LAYOUT_AB  = 2'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_ABT = 2'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_ATB = 2'd2;

  // register map, index from paddr[3:2]
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_ROWS_M  = 2'd0;
  localparam logic [1:0] REG_INNER_N = 2'd1;
  localparam logic [1:0] REG_COLS_P  = 2'd2;
  localparam logic [1:0] REG_LAYOUT  = 2'd3;

  typedef logic signed [VAL_W-1:0] elem_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic clear;      // zero the accumulator
    logic fire;       // multiply held a by the cell's b
    logic acc_en;     // add the product into the accumulator
    logic shift_out;  // pass accumulators one cell towards the output
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/mtm_in_if.sv
// request channel: mode, index and value with valid/ready
// depends on mtm_pkg
`default_nettype none

interface mtm_in_if;
  import mtm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [INDEX_W-1:0]    index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output mode, output index, output value, input ready);
  modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mtm_out_if.sv
// result channel: row, col, product_value and last with valid/ready
// depends on mtm_pkg
`default_nettype none

interface mtm_out_if;
  import mtm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUT_IDX_W-1:0]    row;
  logic [OUT_IDX_W-1:0]    col;
  logic signed [ACC_W-1:0] product_value;
  logic                    last;

  modport source (output valid, output row, output col, output product_value,
                  output last, input ready);
  modport sink   (input valid, input row, input col, input product_value,
                  input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/matrix_multiply_transpose_modes_unit.sv
// top level: register port, element stores, sequencer and chain of column cells
// depends on mtm_pkg, mtm_in_if, mtm_out_if, mtm_ram, mtm_cell
//
//   channel  | kind           | moves
//   ---------+----------------+-------------------------------------------
//   items    | valid/ready in | mode, index, value
//   results  | valid/ready out| row, col, product_value, last
//   apb      | register port  | rows_m, inner_n, cols_p, layout
//
// a compute row reads n*p b elements and then gives the p result transactions
// (n = inner_n, p = cols_p): the b store has one read port,
// so one b element enters the cell chain per cycle.
// reset clears control state and the registers; the stores keep their contents.
// no item is taken until every result of the current row has been delivered;
// a stalled result holds its values.
`default_nettype none

module matrix_multiply_transpose_modes_unit
  import mtm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  mtm_in_if.sink                items,
  mtm_out_if.source             results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [ROWS_W-1:0]   rows_m;
  logic [INNER_W-1:0]  inner_n;
  logic [COLS_W-1:0]   cols_p;
  logic [LAYOUT_W-1:0] layout;

  logic [ROWS_W-1:0]  m_sat;
  logic [INNER_W-1:0] n_sat;
  logic [COLS_W-1:0]  p_sat;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [ROWS_W-1:0]  row_i;
  logic [INNER_W-1:0] k;
  logic [COLS_W-1:0]  j;
  logic [ADDR_W-1:0]  a_addr;
  logic [ADDR_W-1:0]  b_addr;
  logic [ADDR_W-1:0]  b_row;
  logic [ROWS_W-1:0]  a_step;
  logic [INNER_W-1:0] b_jstep;
  logic [COLS_W-1:0]  b_kstep;

  logic [ADDR_W+1:0]  a_start_mul;
  logic [ADDR_W+1:0]  b_start_mul;

  logic fire1;
  logic fire2;
  logic acc_en;

  logic              take;
  logic              apb_wr;
  logic [VAL_W-1:0]  a_rdata;
  logic [VAL_W-1:0]  b_rdata;
  elem_t             a_hold;
  cell_ctl_t         ctl;
  logic              row_ok;
  logic              issue_last_j;

  elem_t b_chain   [MAX_COLS];
  acc_t  acc_chain [MAX_COLS];

  // register port
  assign pready = 1'b1;
  assign apb_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= ROWS_W'(16);
      inner_n <= INNER_W'(64);
      cols_p  <= COLS_W'(16);
      layout  <= LAYOUT_AB;
    end else if (apb_wr) begin
      case (paddr[3:2])
        REG_ROWS_M:  rows_m  <= pwdata[ROWS_W-1:0];
        REG_INNER_N: inner_n <= pwdata[INNER_W-1:0];
        REG_COLS_P:  cols_p  <= pwdata[COLS_W-1:0];
        REG_LAYOUT:  layout  <= pwdata[LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_M:  prdata = APB_DATA_W'(rows_m);
      REG_INNER_N: prdata = APB_DATA_W'(inner_n);
      REG_COLS_P:  prdata = APB_DATA_W'(cols_p);
      REG_LAYOUT:  prdata = APB_DATA_W'(layout);
      default:     prdata = '0;
    endcase
  end

  // sizes clamped to the limits
  assign m_sat = (32'(rows_m) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : rows_m;
  assign n_sat = (32'(inner_n) > MAX_INNER) ? INNER_W'(MAX_INNER) : inner_n;
  assign p_sat = (32'(cols_p) > MAX_COLS) ? COLS_W'(MAX_COLS) : cols_p;

  // input handshake and request decode
  assign items.ready  = (state == ST_IDLE);
  assign take         = items.valid & items.ready;
  assign row_ok       = (items.index < INDEX_W'(m_sat)) && (p_sat != '0);
  assign issue_last_j = (j == '0);

  // element stores
  mtm_ram #(.DEPTH(STORE_DEPTH), .WIDTH(VAL_W)) u_store_a (
    .clk   (clk),
    .we    (take && (items.mode == MODE_LOAD_A)),
    .waddr (items.index),
    .wdata (items.value),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  mtm_ram #(.DEPTH(STORE_DEPTH), .WIDTH(VAL_W)) u_store_b (
    .clk   (clk),
    .we    (take && (items.mode == MODE_LOAD_B)),
    .waddr (items.index),
    .wdata (items.value),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  // start addresses of the row walk
  assign a_start_mul = (ADDR_W+2)'(row_i) * (ADDR_W+2)'(n_sat);
  assign b_start_mul = (ADDR_W+2)'(p_sat - COLS_W'(1)) * (ADDR_W+2)'(n_sat);

  // sequencer state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && (items.mode == MODE_COMPUTE) && row_ok) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = (n_sat == '0) ? ST_DRAIN : ST_RUN;
      end
      ST_RUN: begin
        if (issue_last_j && (k == n_sat - INNER_W'(1))) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!fire1 && !fire2 && !acc_en) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (results.ready && (j == p_sat - COLS_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fire1  <= 1'b0;
      fire2  <= 1'b0;
      acc_en <= 1'b0;
    end else begin
      state  <= state_next;
      fire1  <= (state == ST_RUN) && issue_last_j;
      fire2  <= fire1;
      acc_en <= fire2;
    end
  end

  // address walk: j runs from p-1 down to 0 inside each k
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take) begin
          row_i <= items.index[ROWS_W-1:0];
        end
      end
      ST_SETUP: begin
        k <= '0;
        // n of zero goes straight to unload, so the column count starts at zero
        j <= (n_sat == '0) ? '0 : p_sat - COLS_W'(1);
        if (layout == LAYOUT_ATB) begin
          a_addr <= ADDR_W'(row_i);
          a_step <= m_sat;
        end else begin
          a_addr <= a_start_mul[ADDR_W-1:0];
          a_step <= ROWS_W'(1);
        end
        if (layout == LAYOUT_ABT) begin
          b_row   <= b_start_mul[ADDR_W-1:0];
          b_addr  <= b_start_mul[ADDR_W-1:0];
          b_jstep <= n_sat;
          b_kstep <= COLS_W'(1);
        end else begin
          b_row   <= ADDR_W'(p_sat - COLS_W'(1));
          b_addr  <= ADDR_W'(p_sat - COLS_W'(1));
          b_jstep <= INNER_W'(1);
          b_kstep <= p_sat;
        end
      end
      ST_RUN: begin
        if (issue_last_j) begin
          j      <= p_sat - COLS_W'(1);
          k      <= k + INNER_W'(1);
          a_addr <= a_addr + ADDR_W'(a_step);
          b_row  <= b_row + ADDR_W'(b_kstep);
          b_addr <= b_row + ADDR_W'(b_kstep);
        end else begin
          j      <= j - COLS_W'(1);
          b_addr <= b_addr - ADDR_W'(b_jstep);
        end
      end
      ST_WAIT: begin
        j <= '0;
      end
      ST_DRAIN: begin
        if (results.ready) begin
          j <= j + COLS_W'(1);
        end
      end
      default: ;
    endcase
  end

  // a element of the current k, read with the last b of that k
  always_ff @(posedge clk) begin
    if (fire1) begin
      a_hold <= elem_t'(a_rdata);
    end
  end

  // cell control
  always_comb begin
    ctl.clear     = (state == ST_SETUP);
    ctl.fire      = fire2;
    ctl.acc_en    = acc_en;
    ctl.shift_out = (state == ST_DRAIN) && results.ready;
  end

  // chain of column cells
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    elem_t b_feed;
    acc_t  acc_feed;

    if (c == 0) begin : g_head
      assign b_feed = elem_t'(b_rdata);
    end else begin : g_body
      assign b_feed = b_chain[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_tail
      assign acc_feed = '0;
    end else begin : g_inner
      assign acc_feed = acc_chain[c+1];
    end

    mtm_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .a       (a_hold),
      .b_in    (b_feed),
      .b_out   (b_chain[c]),
      .acc_in  (acc_feed),
      .acc_out (acc_chain[c])
    );
  end

  // result transactions come out of the head cell
  assign results.valid         = (state == ST_DRAIN);
  assign results.row           = row_i[OUT_IDX_W-1:0];
  assign results.col           = j[OUT_IDX_W-1:0];
  assign results.product_value = acc_chain[0];
  assign results.last          = (j == p_sat - COLS_W'(1));

endmodule

`default_nettype wire

>>> rtl/core/mtm_ram.sv
// generic single write port, single read port memory, registered read data
// no dependencies
`default_nettype none

module mtm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/mtm_cell.sv
// one column cell: b shift stage, registered multiply and accumulator
// depends on mtm_pkg
`default_nettype none

module mtm_cell
  import mtm_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  elem_t     a,
  input  elem_t     b_in,
  output elem_t     b_out,
  input  acc_t      acc_in,
  output acc_t      acc_out
);

  elem_t                    b;
  logic signed [PROD_W-1:0] prod;
  acc_t                     acc;

  // b values march along the chain one cell per cycle
  always_ff @(posedge clk) begin
    b <= b_in;
  end

  // product of the broadcast a element and this cell's b element
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

  // clear, accumulate, or hand the sum towards the output during unload
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end else if (ctl.shift_out) begin
      acc <= acc_in;
    end
  end

  assign b_out   = b;
  assign acc_out = acc;

endmodule

`default_nettype wire
